### rtl/dnsx_pkg.sv
// Package for the DNS reply answer extractor.
// Holds shared constants, payload and queue structs, status codes and FSM states.
// No dependencies.
package dnsx_pkg;

    localparam int DEF_PACKET_BYTES = 512;
    localparam int DEF_ANSWER_BYTES = 1024;
    localparam int DEF_NAME_LIMIT   = 524;

    localparam int LABEL_MAX   = 63;
    localparam int HDR_BYTES   = 12;
    localparam int RR_FIXED    = 10;
    localparam int RDLEN_MAX   = 1023;
    localparam int NAME_MARGIN = 256;
    localparam int A_BYTES     = 4;
    localparam int AAAA_BYTES  = 16;

    localparam int OFF_FLAGS1 = 2;
    localparam int OFF_FLAGS2 = 3;
    localparam int OFF_QD     = 4;
    localparam int OFF_AN     = 6;

    localparam logic [7:0] QR_MASK     = 8'h80;
    localparam logic [7:0] OPCODE_MASK = 8'h78;
    localparam logic [7:0] RCODE_MASK  = 8'h0F;
    localparam logic [7:0] DOT_CHAR    = 8'h2E;

    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] TYPE_CNAME = 16'd5;
    localparam logic [15:0] TYPE_PTR   = 16'd12;
    localparam logic [15:0] TYPE_AAAA  = 16'd28;

    localparam int CFG_AW = 3;
    localparam logic REG_WANTED_TYPE  = 1'b0;
    localparam logic REG_WANTED_CLASS = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] packet_byte;
        logic       last_byte;
        logic [9:0] read_index;
    } in_t;

    typedef struct packed {
        logic        is_status;
        logic [3:0]  status;
        logic [31:0] answer_ttl;
        logic [15:0] answer_type;
        logic [9:0]  answer_length;
        logic [7:0]  data_byte;
    } out_t;

    typedef enum logic [1:0] {
        K_LOAD,
        K_LAST,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [9:0] read_index;
    } item_t;

    typedef struct packed {
        logic [15:0] wanted_type;
        logic [15:0] wanted_class;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_OK,
        ST_NOT_RESP,
        ST_OPCODE,
        ST_RCODE,
        ST_NO_ANSWER,
        ST_TRUNC,
        ST_NO_MATCH,
        ST_OVERRUN,
        ST_TOO_LARGE,
        ST_PTR_BITS,
        ST_PTR_BACK,
        ST_NAME_LONG,
        ST_A_LEN,
        ST_AAAA_LEN,
        ST_UNSUP
    } status_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_HDR,
        B_Q_ISSUE,
        B_Q_DATA,
        B_A_ISSUE,
        B_A_DATA,
        B_A_CHK,
        B_F_ISSUE,
        B_F_DATA,
        B_A_MATCH,
        B_R_CHK,
        B_N_ISSUE,
        B_N_DATA,
        B_N_PTR_ISSUE,
        B_N_PTR_DATA,
        B_N_COPY_ISSUE,
        B_N_COPY_DATA,
        B_AD_ISSUE,
        B_AD_DATA,
        B_EMIT,
        B_RD
    } bstate_t;

endpackage

### rtl/dnsx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dnsx_ram #(
    parameter int W = 8,
    parameter int D = 512
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/dnsx_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on dnsx_pkg.
module dnsx_front import dnsx_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_data,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);

    item_t      ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      item_c;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rp_reg];

    always_comb
    begin
        item_c.data       = in_data.packet_byte;
        item_c.read_index = in_data.read_index;
        if (in_data.op)
        begin
            item_c.kind = K_READ;
        end
        else if (in_data.last_byte)
        begin
            item_c.kind = K_LAST;
        end
        else
        begin
            item_c.kind = K_LOAD;
        end
    end

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= item_c;
        end
    end

endmodule

### rtl/dnsx_back.sv
// Back end: packet store, parse sequencer, answer store and output register.
// Depends on dnsx_pkg and dnsx_ram.
module dnsx_back import dnsx_pkg::*; #(
    parameter int PACKET_BYTES = DEF_PACKET_BYTES,
    parameter int ANSWER_BYTES = DEF_ANSWER_BYTES,
    parameter int NAME_LIMIT   = DEF_NAME_LIMIT
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    localparam int PAW = $clog2(PACKET_BYTES);
    localparam int AAW = $clog2(ANSWER_BYTES);
    localparam int CW  = $clog2(PACKET_BYTES + 1);
    localparam int IW  = $clog2(PACKET_BYTES + 65536) + 1;
    localparam int OW  = 11;

    bstate_t state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    out_t    out_reg, out_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [9:0]    sal_reg, sal_next;

    logic [7:0]    f1_reg, f1_next, f2_reg, f2_next;
    logic [15:0]   qd_reg, qd_next, an_reg, an_next;
    logic [CW-1:0] plen_reg, plen_next;
    logic [IW-1:0] i_reg, i_next;
    logic [15:0]   q_reg, q_next, cur_reg, cur_next;
    logic [5:0]    k_reg, k_next, b_reg, b_next;
    logic [OW-1:0] o_reg, o_next, alen_reg, alen_next;
    logic [CW-1:0] low_reg, low_next;
    logic [7:0]    hb_reg, hb_next;
    logic [79:0]   fld_reg, fld_next;
    status_t       st_reg, st_next;
    logic          rok_reg, rok_next;
    logic          pz_reg, pz_next;

    logic [IW-1:0]  fidx;
    logic [PAW-1:0] praddr;
    logic [7:0]     prdata;
    logic           pw_en;
    logic [7:0]     pb;
    logic           aw_req;
    logic [OW-1:0]  aw_addr;
    logic [7:0]     aw_data;
    logic           aw_en;
    logic [7:0]     ardata;

    logic [IW-1:0] plen_x;
    logic [15:0]   rtype, rclass, rdlen;
    logic [31:0]   rttl;
    logic          i_lt, q_more, b_ptr, b_zero, chk_over, mismatch, last_rr;
    logic          is_name, is_addr, n_go, k_eq_b, k_need, lab_long;
    logic [5:0]    need;
    logic [OW-1:0] oo;
    logic [15:0]   p16;
    logic [13:0]   p14, pp;
    status_t       hdr_st, r_st, ptr_st;
    logic [OW-1:0] alen_clip;

    assign plen_x   = IW'(plen_reg);
    assign rtype    = fld_reg[79:64];
    assign rclass   = fld_reg[63:48];
    assign rttl     = fld_reg[47:16];
    assign rdlen    = fld_reg[15:0];
    assign pb       = pz_reg ? 8'd0 : prdata;
    assign i_lt     = i_reg < plen_x;
    assign q_more   = (q_reg < qd_reg) && i_lt;
    assign b_ptr    = pb > 8'(LABEL_MAX);
    assign b_zero   = (pb == 8'd0);
    assign chk_over = (i_reg + IW'(RR_FIXED)) > plen_x;
    assign mismatch = (rtype != cfg.wanted_type) || (rclass != cfg.wanted_class);
    assign last_rr  = ({1'b0, cur_reg} + 17'd1) == {1'b0, an_reg};
    assign is_name  = (rtype == TYPE_CNAME) || (rtype == TYPE_PTR);
    assign is_addr  = (rtype == TYPE_A) || (rtype == TYPE_AAAA);
    assign need     = (rtype == TYPE_A) ? 6'(A_BYTES) : 6'(AAAA_BYTES);
    assign n_go     = i_lt && (o_reg < OW'(RDLEN_MAX - NAME_MARGIN));
    assign k_eq_b   = (k_reg == b_reg);
    assign k_need   = (k_reg == need);
    assign oo       = o_reg + ((o_reg != '0) ? OW'(1) : OW'(0));
    assign lab_long = (12'(oo) + 12'(pb)) > 12'(NAME_LIMIT);
    assign p16      = {hb_reg, pb};
    assign p14      = p16[13:0];
    assign pp       = p14 - 14'(HDR_BYTES);
    assign aw_en    = aw_req && (aw_addr < OW'(ANSWER_BYTES));
    assign alen_clip = (alen_reg > OW'(ANSWER_BYTES)) ? OW'(ANSWER_BYTES) : alen_reg;

    assign q_pop = (state_reg == B_IDLE) && q_valid
                   && ((q_item.kind == K_LOAD) || !out_valid_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (bc_reg < CW'(HDR_BYTES))
            hdr_st = ST_TRUNC;
        else if ((f1_reg & QR_MASK) == 8'd0)
            hdr_st = ST_NOT_RESP;
        else if ((f1_reg & OPCODE_MASK) != 8'd0)
            hdr_st = ST_OPCODE;
        else if ((f2_reg & RCODE_MASK) != 8'd0)
            hdr_st = ST_RCODE;
        else if (an_reg == 16'd0)
            hdr_st = ST_NO_ANSWER;
        else
            hdr_st = ST_OK;
    end

    always_comb
    begin
        if ((i_reg + IW'(rdlen)) > plen_x)
            r_st = ST_OVERRUN;
        else if (rdlen > 16'(RDLEN_MAX))
            r_st = ST_TOO_LARGE;
        else if (is_name)
            r_st = ST_OK;
        else if (is_addr)
        begin
            if (rdlen != 16'(need))
                r_st = (rtype == TYPE_A) ? ST_A_LEN : ST_AAAA_LEN;
            else
                r_st = ST_OK;
        end
        else
            r_st = ST_UNSUP;
    end

    always_comb
    begin
        if (p16[15:14] != 2'b11)
            ptr_st = ST_PTR_BITS;
        else if (p14 < 14'(HDR_BYTES))
            ptr_st = ST_PTR_BACK;
        else if (pp >= 14'(low_reg))
            ptr_st = ST_PTR_BACK;
        else
            ptr_st = ST_OK;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_item.kind)
                        K_LAST:  state_next = B_HDR;
                        K_READ:  state_next = B_RD;
                        default: state_next = B_IDLE;
                    endcase
                end
            end
            B_HDR:          state_next = (hdr_st != ST_OK) ? B_EMIT : B_Q_ISSUE;
            B_Q_ISSUE:      state_next = q_more ? B_Q_DATA : B_A_ISSUE;
            B_Q_DATA:       state_next = B_Q_ISSUE;
            B_A_ISSUE:      state_next = i_lt ? B_A_DATA : B_A_CHK;
            B_A_DATA:       state_next = (b_ptr || b_zero) ? B_A_CHK : B_A_ISSUE;
            B_A_CHK:        state_next = chk_over ? B_EMIT : B_F_ISSUE;
            B_F_ISSUE:      state_next = B_F_DATA;
            B_F_DATA:       state_next = (k_reg == 6'(RR_FIXED - 1)) ? B_A_MATCH : B_F_ISSUE;
            B_A_MATCH:
            begin
                if (mismatch)
                    state_next = last_rr ? B_EMIT : B_A_ISSUE;
                else
                    state_next = B_R_CHK;
            end
            B_R_CHK:
            begin
                if (r_st != ST_OK)
                    state_next = B_EMIT;
                else if (is_name)
                    state_next = B_N_ISSUE;
                else
                    state_next = B_AD_ISSUE;
            end
            B_N_ISSUE:      state_next = n_go ? B_N_DATA : B_EMIT;
            B_N_DATA:
            begin
                if (b_ptr)
                    state_next = B_N_PTR_ISSUE;
                else if (b_zero || lab_long)
                    state_next = B_EMIT;
                else
                    state_next = B_N_COPY_ISSUE;
            end
            B_N_PTR_ISSUE:  state_next = B_N_PTR_DATA;
            B_N_PTR_DATA:   state_next = (ptr_st != ST_OK) ? B_EMIT : B_N_ISSUE;
            B_N_COPY_ISSUE: state_next = k_eq_b ? B_N_ISSUE : B_N_COPY_DATA;
            B_N_COPY_DATA:  state_next = B_N_COPY_ISSUE;
            B_AD_ISSUE:     state_next = k_need ? B_EMIT : B_AD_DATA;
            B_AD_DATA:      state_next = B_AD_ISSUE;
            B_EMIT:         state_next = B_IDLE;
            B_RD:           state_next = B_IDLE;
            default:        state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next  = out_reg;
        bc_next   = bc_reg;
        sal_next  = sal_reg;
        f1_next   = f1_reg;
        f2_next   = f2_reg;
        qd_next   = qd_reg;
        an_next   = an_reg;
        plen_next = plen_reg;
        i_next    = i_reg;
        q_next    = q_reg;
        cur_next  = cur_reg;
        k_next    = k_reg;
        b_next    = b_reg;
        o_next    = o_reg;
        alen_next = alen_reg;
        low_next  = low_reg;
        hb_next   = hb_reg;
        fld_next  = fld_reg;
        st_next   = st_reg;
        rok_next  = rok_reg;
        fidx      = i_reg;
        pw_en     = 1'b0;
        aw_req    = 1'b0;
        aw_addr   = o_reg;
        aw_data   = pb;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_item.kind == K_READ)
                    begin
                        rok_next = q_item.read_index < sal_reg;
                    end
                    else if (bc_reg < CW'(PACKET_BYTES))
                    begin
                        pw_en   = 1'b1;
                        bc_next = bc_reg + CW'(1);
                        if (bc_reg == CW'(OFF_FLAGS1))
                            f1_next = q_item.data;
                        if (bc_reg == CW'(OFF_FLAGS2))
                            f2_next = q_item.data;
                        if (bc_reg == CW'(OFF_QD))
                            qd_next[15:8] = q_item.data;
                        if (bc_reg == CW'(OFF_QD + 1))
                            qd_next[7:0] = q_item.data;
                        if (bc_reg == CW'(OFF_AN))
                            an_next[15:8] = q_item.data;
                        if (bc_reg == CW'(OFF_AN + 1))
                            an_next[7:0] = q_item.data;
                    end
                end
            end
            B_HDR:
            begin
                st_next   = hdr_st;
                plen_next = bc_reg - CW'(HDR_BYTES);
                i_next    = '0;
                q_next    = '0;
                cur_next  = '0;
            end
            B_Q_DATA:
            begin
                if (b_ptr)
                begin
                    i_next = i_reg + IW'(6);
                    q_next = q_reg + 16'd1;
                end
                else if (b_zero)
                begin
                    i_next = i_reg + IW'(5);
                    q_next = q_reg + 16'd1;
                end
                else
                    i_next = i_reg + IW'(pb) + IW'(1);
            end
            B_A_DATA:
            begin
                if (b_ptr)
                    i_next = i_reg + IW'(2);
                else if (b_zero)
                    i_next = i_reg + IW'(1);
                else
                    i_next = i_reg + IW'(pb) + IW'(1);
            end
            B_A_CHK:
            begin
                k_next = '0;
                if (chk_over)
                    st_next = ST_OVERRUN;
            end
            B_F_ISSUE:
            begin
                fidx = i_reg + IW'(k_reg);
            end
            B_F_DATA:
            begin
                fld_next = {fld_reg[71:0], pb};
                k_next   = k_reg + 6'd1;
            end
            B_A_MATCH:
            begin
                if (mismatch)
                begin
                    cur_next = cur_reg + 16'd1;
                    i_next   = i_reg + IW'(RR_FIXED) + IW'(rdlen);
                    if (last_rr)
                        st_next = ST_NO_MATCH;
                end
                else
                    i_next = i_reg + IW'(RR_FIXED);
            end
            B_R_CHK:
            begin
                st_next  = r_st;
                low_next = plen_reg;
                o_next   = '0;
                k_next   = '0;
            end
            B_N_ISSUE:
            begin
                if (!n_go)
                begin
                    st_next   = ST_OK;
                    alen_next = o_reg;
                end
            end
            B_N_DATA:
            begin
                if (b_ptr)
                    hb_next = pb;
                else if (b_zero)
                begin
                    st_next   = ST_OK;
                    alen_next = o_reg;
                end
                else
                begin
                    aw_req  = (o_reg != '0);
                    aw_addr = o_reg;
                    aw_data = DOT_CHAR;
                    b_next  = pb[5:0];
                    k_next  = '0;
                    if (lab_long)
                        st_next = ST_NAME_LONG;
                    else
                        o_next = oo;
                end
            end
            B_N_PTR_ISSUE:
            begin
                fidx = i_reg + IW'(1);
            end
            B_N_PTR_DATA:
            begin
                st_next  = ptr_st;
                i_next   = IW'(pp);
                low_next = CW'(pp);
            end
            B_N_COPY_ISSUE:
            begin
                fidx = i_reg + IW'(1) + IW'(k_reg);
                if (k_eq_b)
                begin
                    o_next = o_reg + OW'(b_reg);
                    i_next = i_reg + IW'(b_reg) + IW'(1);
                end
            end
            B_N_COPY_DATA:
            begin
                aw_req  = 1'b1;
                aw_addr = o_reg + OW'(k_reg);
                k_next  = k_reg + 6'd1;
            end
            B_AD_ISSUE:
            begin
                fidx = i_reg + IW'(k_reg);
                if (k_need)
                begin
                    st_next   = ST_OK;
                    alen_next = OW'(need);
                end
            end
            B_AD_DATA:
            begin
                aw_req  = 1'b1;
                aw_addr = OW'(k_reg);
                k_next  = k_reg + 6'd1;
            end
            B_EMIT:
            begin
                out_valid_next         = 1'b1;
                out_next.is_status     = 1'b1;
                out_next.status        = st_reg;
                out_next.data_byte     = 8'd0;
                bc_next                = '0;
                if (st_reg == ST_OK)
                begin
                    out_next.answer_ttl    = rttl;
                    out_next.answer_type   = rtype;
                    out_next.answer_length = alen_clip[9:0];
                    sal_next               = alen_clip[9:0];
                end
                else
                begin
                    out_next.answer_ttl    = 32'd0;
                    out_next.answer_type   = 16'd0;
                    out_next.answer_length = 10'd0;
                    sal_next               = 10'd0;
                end
            end
            B_RD:
            begin
                out_valid_next         = 1'b1;
                out_next.is_status     = 1'b0;
                out_next.status        = ST_OK;
                out_next.answer_ttl    = 32'd0;
                out_next.answer_type   = 16'd0;
                out_next.answer_length = sal_reg;
                out_next.data_byte     = rok_reg ? ardata : 8'd0;
            end
            default:
            begin
            end
        endcase
        pz_next = !(fidx < plen_x);
    end

    assign praddr = PAW'(fidx + IW'(HDR_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            bc_reg        <= '0;
            sal_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bc_reg        <= bc_next;
            sal_reg       <= sal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        f1_reg   <= f1_next;
        f2_reg   <= f2_next;
        qd_reg   <= qd_next;
        an_reg   <= an_next;
        plen_reg <= plen_next;
        i_reg    <= i_next;
        q_reg    <= q_next;
        cur_reg  <= cur_next;
        k_reg    <= k_next;
        b_reg    <= b_next;
        o_reg    <= o_next;
        alen_reg <= alen_next;
        low_reg  <= low_next;
        hb_reg   <= hb_next;
        fld_reg  <= fld_next;
        st_reg   <= st_next;
        rok_reg  <= rok_next;
        pz_reg   <= pz_next;
    end

    dnsx_ram #(.W(8), .D(PACKET_BYTES)) u_pkt_ram (
        .clk   (clk),
        .we    (pw_en),
        .waddr (bc_reg[PAW-1:0]),
        .wdata (q_item.data),
        .raddr (praddr),
        .rdata (prdata)
    );

    dnsx_ram #(.W(8), .D(ANSWER_BYTES)) u_ans_ram (
        .clk   (clk),
        .we    (aw_en),
        .waddr (aw_addr[AAW-1:0]),
        .wdata (aw_data),
        .raddr (q_item.read_index[AAW-1:0]),
        .rdata (ardata)
    );

endmodule

### rtl/dns_reply_answer_extractor.sv
// Top level of the DNS reply answer extractor: APB registers, front queue, back end.
// Depends on dnsx_pkg, dnsx_front, dnsx_back.
//
// Usage: in_data carries one transaction per accepted in_valid/in_ready beat.
// op 0 loads one packet byte into the packet store; with last_byte set the packet
// is parsed and one status result appears on out_data. op 1 reads one byte of the
// stored answer and gives one data result.
// A load byte is written to the packet store as the back end pops it, while the store has
// room. After the last byte the parse sequencer walks the packet store, each byte fetch
// in an issue state (address) then a data state (registered read data); a read addresses
// the answer store as it is popped, then passes the registered byte to the output register.
// A two-entry queue sits between the input handshake and the back end; a held
// result in the output register stalls only transactions that make a result.
// Reset clears the queue, byte count, stored answer length and output valid, and
// sets wanted_type and wanted_class to 1. If out_ready stays low the result holds.
// Registers: wanted_type at 0x0, wanted_class at 0x4, written via APB.
module dns_reply_answer_extractor import dnsx_pkg::*; #(
    parameter int PACKET_BYTES = DEF_PACKET_BYTES,
    parameter int ANSWER_BYTES = DEF_ANSWER_BYTES,
    parameter int NAME_LIMIT   = DEF_NAME_LIMIT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WANTED_CLASS) ? {16'd0, cfg_reg.wanted_class}
                                                   : {16'd0, cfg_reg.wanted_type};

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_WANTED_TYPE)
                cfg_next.wanted_type = pwdata[15:0];
            else
                cfg_next.wanted_class = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wanted_type  <= TYPE_A;
            cfg_reg.wanted_class <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dnsx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dnsx_back #(
        .PACKET_BYTES (PACKET_BYTES),
        .ANSWER_BYTES (ANSWER_BYTES),
        .NAME_LIMIT   (NAME_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/dnsx_checker.sv
// Port-level checker for the DNS reply answer extractor, bound to the top level.
// Depends on dnsx_pkg.
module dnsx_checker import dnsx_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic pready,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data) && pready)
        else $error("input transaction changed while waiting");

    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_status |->
            out_data.status == ST_OK && out_data.answer_ttl == 32'd0
            && out_data.answer_type == 16'd0)
        else $error("read transaction carries status fields");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_status && out_data.status != ST_OK |->
            out_data.answer_ttl == 32'd0 && out_data.answer_type == 16'd0
            && out_data.answer_length == 10'd0 && out_data.data_byte == 8'd0)
        else $error("failed parse left answer fields set");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_status |-> out_data.status <= ST_UNSUP)
        else $error("status code out of range");

endmodule

bind dns_reply_answer_extractor dnsx_checker u_chk (.*);

### tb/sv/dns_reply_answer_extractor_tb.sv
// Testbench for dns_reply_answer_extractor: random DNS replies and answer reads,
// checked against a built-in answer predictor in a small scoreboard class.
// Depends on dnsx_pkg and the dns_reply_answer_extractor RTL.
module dns_reply_answer_extractor_tb;
    import dnsx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class answer_scoreboard;
        logic [15:0] want_type;
        logic [15:0] want_class;
        logic [7:0]  pkt_mem [DEF_PACKET_BYTES];
        int unsigned pkt_count;
        logic [7:0]  ans_mem [DEF_ANSWER_BYTES];
        int unsigned ans_len;
        int unsigned pay_len;
        out_t        pending_q [$];
        int          errors;
        int          n_status;
        int          n_reads;
        logic [15:0] status_seen;

        function new();
            want_type = 16'd1;
            want_class = 16'd1;
            pkt_count = 0;
            ans_len = 0;
            pay_len = 0;
            errors = 0;
            n_status = 0;
            n_reads = 0;
            status_seen = '0;
            foreach (pkt_mem[k]) pkt_mem[k] = '0;
            foreach (ans_mem[k]) ans_mem[k] = '0;
        endfunction

        function int unsigned pay(int unsigned i);
            if (i < pay_len && HDR_BYTES + i < DEF_PACKET_BYTES)
                return pkt_mem[HDR_BYTES + i];
            return 0;
        endfunction

        function void put(int unsigned idx, int unsigned v);
            if (idx < DEF_ANSWER_BYTES) ans_mem[idx] = v[7:0];
        endfunction

        function status_t extract(output int unsigned ttl, output int unsigned rtype_o,
                                  output int unsigned alen);
            int unsigned n, qd, an, i, q, cur, rtype, rclass, rttl, rdlen, b, k;
            int unsigned lowest, o, p, need;
            bit done, fin;
            ttl = 0;
            rtype_o = 0;
            alen = 0;
            n = pkt_count;
            i = 0;
            q = 0;
            cur = 0;
            rtype = 0;
            rclass = 0;
            rttl = 0;
            rdlen = 0;
            if (n < HDR_BYTES) return ST_TRUNC;
            if ((pkt_mem[OFF_FLAGS1] & QR_MASK) == 0) return ST_NOT_RESP;
            if ((pkt_mem[OFF_FLAGS1] & OPCODE_MASK) != 0) return ST_OPCODE;
            if ((pkt_mem[OFF_FLAGS2] & RCODE_MASK) != 0) return ST_RCODE;
            qd = {pkt_mem[OFF_QD], pkt_mem[OFF_QD + 1]};
            an = {pkt_mem[OFF_AN], pkt_mem[OFF_AN + 1]};
            if (an == 0) return ST_NO_ANSWER;
            pay_len = n - HDR_BYTES;
            while (q < qd && i < pay_len)
            begin
                b = pay(i);
                if (b > LABEL_MAX)
                begin
                    i += 6;
                    q++;
                end
                else if (b == 0)
                begin
                    i += 5;
                    q++;
                end
                else i += b + 1;
            end
            while (cur < an)
            begin
                done = 0;
                while (!done && i < pay_len)
                begin
                    b = pay(i);
                    if (b > LABEL_MAX)
                    begin
                        i += 2;
                        done = 1;
                    end
                    else if (b == 0)
                    begin
                        i += 1;
                        done = 1;
                    end
                    else i += b + 1;
                end
                if (i + RR_FIXED > pay_len) return ST_OVERRUN;
                rtype = (pay(i) << 8) | pay(i + 1);
                rclass = (pay(i + 2) << 8) | pay(i + 3);
                rttl = (pay(i + 4) << 24) | (pay(i + 5) << 16) | (pay(i + 6) << 8) | pay(i + 7);
                rdlen = (pay(i + 8) << 8) | pay(i + 9);
                i += RR_FIXED;
                if (rtype != want_type || rclass != want_class)
                begin
                    cur++;
                    i += rdlen;
                    continue;
                end
                break;
            end
            if (cur == an) return ST_NO_MATCH;
            if (i + rdlen > pay_len) return ST_OVERRUN;
            if (rdlen > RDLEN_MAX) return ST_TOO_LARGE;
            if (rtype == TYPE_CNAME || rtype == TYPE_PTR)
            begin
                lowest = pay_len;
                o = 0;
                fin = 0;
                while (!fin && i < pay_len && o + NAME_MARGIN < RDLEN_MAX)
                begin
                    b = pay(i);
                    if (b > LABEL_MAX)
                    begin
                        p = (b << 8) | pay(i + 1);
                        if ((p & 32'hC000) != 32'hC000) return ST_PTR_BITS;
                        p &= 32'h3FFF;
                        if (p < HDR_BYTES) return ST_PTR_BACK;
                        p -= HDR_BYTES;
                        if (p >= lowest) return ST_PTR_BACK;
                        lowest = p;
                        i = p;
                    end
                    else if (b == 0) fin = 1;
                    else
                    begin
                        if (o != 0)
                        begin
                            put(o, DOT_CHAR);
                            o++;
                        end
                        if (o + b > DEF_NAME_LIMIT) return ST_NAME_LONG;
                        for (k = 0; k < b; k++) put(o + k, pay(i + 1 + k));
                        o += b;
                        i += b + 1;
                    end
                end
                alen = (o > DEF_ANSWER_BYTES) ? DEF_ANSWER_BYTES : o;
            end
            else if (rtype == TYPE_AAAA || rtype == TYPE_A)
            begin
                need = (rtype == TYPE_A) ? A_BYTES : AAAA_BYTES;
                if (rdlen != need) return (rtype == TYPE_A) ? ST_A_LEN : ST_AAAA_LEN;
                for (k = 0; k < need; k++) put(k, pay(i + k));
                alen = need;
            end
            else return ST_UNSUP;
            ttl = rttl;
            rtype_o = rtype;
            return ST_OK;
        endfunction

        function void note_input(in_t x);
            out_t e;
            status_t st;
            int unsigned ttl, rt, al;
            e = '0;
            if (x.op)
            begin
                e.answer_length = ans_len[9:0];
                if (x.read_index < ans_len) e.data_byte = ans_mem[x.read_index];
                pending_q.push_back(e);
                return;
            end
            if (pkt_count < DEF_PACKET_BYTES)
            begin
                pkt_mem[pkt_count] = x.packet_byte;
                pkt_count++;
            end
            if (!x.last_byte) return;
            st = extract(ttl, rt, al);
            if (st != ST_OK)
            begin
                ttl = 0;
                rt = 0;
                al = 0;
            end
            ans_len = al & 32'h3FF;
            pkt_count = 0;
            e.is_status = 1'b1;
            e.status = st;
            e.answer_ttl = ttl;
            e.answer_type = rt[15:0];
            e.answer_length = al[9:0];
            pending_q.push_back(e);
        endfunction

        function void check_result(out_t a);
            out_t e;
            if (pending_q.size() == 0)
            begin
                $error("result with nothing expected: %h", a);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (e.is_status)
            begin
                n_status++;
                status_seen[e.status] = 1'b1;
            end
            else n_reads++;
            if (a.is_status !== e.is_status)
            begin
                $error("is_status expected %0d actual %0d", e.is_status, a.is_status);
                errors++;
            end
            if (a.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, a.status);
                errors++;
            end
            if (a.answer_ttl !== e.answer_ttl)
            begin
                $error("answer_ttl expected %h actual %h", e.answer_ttl, a.answer_ttl);
                errors++;
            end
            if (a.answer_type !== e.answer_type)
            begin
                $error("answer_type expected %0d actual %0d", e.answer_type, a.answer_type);
                errors++;
            end
            if (a.answer_length !== e.answer_length)
            begin
                $error("answer_length expected %0d actual %0d",
                       e.answer_length, a.answer_length);
                errors++;
            end
            if (a.data_byte !== e.data_byte)
            begin
                $error("data_byte expected %h actual %h", e.data_byte, a.data_byte);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    in_t               in_data;
    logic              out_valid;
    logic              out_ready;
    out_t              out_data;

    answer_scoreboard sb;
    logic [7:0] pkt_bytes [$];
    int unsigned name_offs [$];
    logic [15:0] cur_type;
    logic [15:0] cur_class;
    bit calm;
    int items_sent;
    int out_stall;

    dns_reply_answer_extractor uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int draw_gap();
        if (calm) return 0;
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(out_data);
                out_stall = draw_gap();
            end
            else if (out_stall > 0) out_stall--;
            out_ready <= (out_stall == 0);
        end
    end

    task automatic send(in_t x);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= x;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(x);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(logic idx, logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom_range(0, 65535)), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_WANTED_TYPE) sb.want_type = val;
        else sb.want_class = val;
    endtask

    task automatic set_config(logic [15:0] t, logic [15:0] c);
        drain();
        reg_write(REG_WANTED_TYPE, t);
        reg_write(REG_WANTED_CLASS, c);
        cur_type = t;
        cur_class = c;
    endtask

    task automatic send_packet();
        in_t x;
        for (int k = 0; k < pkt_bytes.size(); k++)
        begin
            x.op = 1'b0;
            x.packet_byte = pkt_bytes[k];
            x.last_byte = (k == pkt_bytes.size() - 1);
            x.read_index = 10'($urandom);
            send(x);
        end
    endtask

    task automatic send_read(logic [9:0] idx);
        in_t x;
        x.op = 1'b1;
        x.packet_byte = 8'($urandom);
        x.last_byte = 1'($urandom);
        x.read_index = idx;
        send(x);
    endtask

    function automatic void add16(int unsigned v);
        pkt_bytes.push_back(v[15:8]);
        pkt_bytes.push_back(v[7:0]);
    endfunction

    function automatic void add_name(bit allow_ptr);
        int labels;
        int len;
        labels = $urandom_range(0, 3);
        for (int l = 0; l < labels; l++)
        begin
            name_offs.push_back(pkt_bytes.size());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, LABEL_MAX)
                                               : $urandom_range(1, 8);
            pkt_bytes.push_back(len[7:0]);
            for (int c = 0; c < len; c++) pkt_bytes.push_back(8'($urandom_range(97, 122)));
        end
        if (allow_ptr && name_offs.size() != 0 && $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 11))
                0: add16($urandom_range(0, 16'hBFFF));
                1: add16(16'hC000 | $urandom_range(0, 11));
                2: add16(16'hC000 | (pkt_bytes.size() + 4));
                default: add16(16'hC000 | name_offs[$urandom_range(0, name_offs.size() - 1)]);
            endcase
        end
        else pkt_bytes.push_back(8'h00);
    endfunction

    function automatic void build_reply();
        int qd, an, len, start;
        logic [15:0] rt, rc;
        pkt_bytes.delete();
        name_offs.delete();
        add16($urandom_range(0, 65535));
        pkt_bytes.push_back(QR_MASK | 8'($urandom & 8'h07));
        pkt_bytes.push_back(8'($urandom & 8'hF0));
        qd = $urandom_range(0, 2);
        an = $urandom_range(1, 4);
        add16(qd);
        add16(an);
        add16($urandom_range(0, 2));
        add16($urandom_range(0, 2));
        for (int q = 0; q < qd; q++)
        begin
            add_name(1);
            add16($urandom_range(0, 65535));
            add16($urandom_range(0, 65535));
        end
        for (int a = 0; a < an; a++)
        begin
            add_name(1);
            case ($urandom_range(0, 7))
                0: rt = TYPE_A;
                1: rt = TYPE_AAAA;
                2: rt = TYPE_CNAME;
                3: rt = TYPE_PTR;
                4: rt = 16'($urandom_range(0, 65535));
                default: rt = cur_type;
            endcase
            rc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : cur_class;
            add16(rt);
            add16(rc);
            add16($urandom_range(0, 65535));
            add16($urandom_range(0, 65535));
            start = pkt_bytes.size();
            add16(0);
            if (rt == TYPE_A || rt == TYPE_AAAA)
            begin
                len = (rt == TYPE_A) ? A_BYTES : AAAA_BYTES;
                if ($urandom_range(0, 7) == 0) len = len + $urandom_range(0, 2) - 1;
                for (int c = 0; c < len; c++) pkt_bytes.push_back(8'($urandom));
            end
            else if (rt == TYPE_CNAME || rt == TYPE_PTR) add_name(1);
            else
            begin
                len = $urandom_range(0, 8);
                for (int c = 0; c < len; c++) pkt_bytes.push_back(8'($urandom));
            end
            len = pkt_bytes.size() - start - 2;
            pkt_bytes[start] = len[15:8];
            pkt_bytes[start + 1] = len[7:0];
        end
    endfunction

    function automatic void damage();
        int pos;
        case ($urandom_range(0, 3))
            0:
            begin
                pos = $urandom_range(0, pkt_bytes.size() - 1);
                pkt_bytes[pos] = pkt_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
            1: pkt_bytes = pkt_bytes[0:$urandom_range(0, pkt_bytes.size() - 1)];
            2: pkt_bytes[$urandom_range(2, 7)] = 8'($urandom);
            default: repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
        endcase
    endfunction

    task automatic read_answer();
        int n;
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0) send_read(10'($urandom));
            else send_read(10'($urandom_range(0, sb.ans_len + 2)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        out_stall = 0;
        calm = 1'b0;
        items_sent = 0;
        cur_type = TYPE_A;
        cur_class = 16'd1;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reads on empty store, short packet, plain A answer
        send_read(10'd0);
        send_read(10'd1023);
        pkt_bytes.delete();
        repeat (11) pkt_bytes.push_back(8'($urandom));
        send_packet();
        pkt_bytes = '{8'h12, 8'h34, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
                      8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h04, 8'hFF,
                      8'h00, 8'hA5, 8'h5A};
        send_packet();
        send_read(10'd0);
        send_read(10'd3);
        send_read(10'd4);

        for (int pk = 0; items_sent < 1550; pk++)
        begin
            if (pk % 8 == 7)
            begin
                calm = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 6))
                    0: set_config(TYPE_A, 16'd1);
                    1: set_config(TYPE_AAAA, 16'd1);
                    2: set_config(TYPE_CNAME, $urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
                    3: set_config(TYPE_PTR, 16'd1);
                    4: set_config(16'h0000, 16'h0000);
                    5: set_config(16'hFFFF, 16'hFFFF);
                    default: set_config(16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)));
                endcase
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    pkt_bytes.delete();
                    repeat ($urandom_range(1, 20)) pkt_bytes.push_back(8'($urandom));
                end
                1, 2:
                begin
                    build_reply();
                    damage();
                end
                default: build_reply();
            endcase
            if (pk == 5)
                while (pkt_bytes.size() < DEF_PACKET_BYTES + 40)
                    pkt_bytes.push_back(8'($urandom));
            send_packet();
            read_answer();
        end
        drain();

        $display("Covered %0d transactions: %0d parse results and %0d answer reads.",
                 items_sent, sb.n_status, sb.n_reads);
        $display("Status codes returned (bit per code): %b", sb.status_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
